### rtl/tps_pkg.sv
// Shared types and codes for the twin prime search block.
// Control word layout, condition and action codes, status bundle.
// No dependencies.
package tps_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int TWIN_GAP            = 2;

   localparam int COND_W = 4;
   localparam int ACT_W  = 4;
   localparam int STEP_W = 5;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 4'd2;
   localparam logic [COND_W-1:0] COND_OVER     = 4'd3;
   localparam logic [COND_W-1:0] COND_LE1      = 4'd4;
   localparam logic [COND_W-1:0] COND_LT4      = 4'd5;
   localparam logic [COND_W-1:0] COND_EVEN     = 4'd6;
   localparam logic [COND_W-1:0] COND_DIV_BUSY = 4'd7;
   localparam logic [COND_W-1:0] COND_Q_LT_D   = 4'd8;
   localparam logic [COND_W-1:0] COND_REM_ZERO = 4'd9;
   localparam logic [COND_W-1:0] COND_SECOND   = 4'd10;
   localparam logic [COND_W-1:0] COND_RSP_FREE = 4'd11;

   // datapath actions
   localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_P   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_SET_N_P  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_SET_D3   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_DIV_GO   = 4'd4;
   localparam logic [ACT_W-1:0] ACT_D_ADD2   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_SET_N_P2 = 4'd6;
   localparam logic [ACT_W-1:0] ACT_INC_P    = 4'd7;
   localparam logic [ACT_W-1:0] ACT_WR_FOUND = 4'd8;
   localparam logic [ACT_W-1:0] ACT_WR_FAIL  = 4'd9;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
      logic [ACT_W-1:0]  act;
   } ctl_type;

   typedef struct packed {
      logic no_req;
      logic over;
      logic le1;
      logic lt4;
      logic even;
      logic div_busy;
      logic q_lt_d;
      logic rem_zero;
      logic second;
      logic rsp_free;
   } stat_type;

endpackage

### rtl/twin_prime_search.sv
// Twin prime search, top level: datapath, request/response handshake.
// Depends on tps_pkg, tps_div and tps_seq.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   request  | req_valid / req_ready  | req_start_value
//   response | rsp_valid / rsp_ready  | rsp_lower_prime, rsp_upper_prime,
//            |                        | rsp_pair_found
//
// Run time: data dependent. Each trial divisor is one pass of the shared bit-serial
//   divider; a candidate n takes about sqrt(n)/2 divisors, and a request sums over
//   all candidates walked until a pair is found or the top of the range is reached.
// Reset: synchronous, clears the step counter, divider count and response valid.
// Stalls: one request in flight; the next request is taken as soon as the result
//   sits in the response register, and a full register holds the sequencer only
//   when a new result is ready to be written.
module twin_prime_search #(
   parameter int VALUE_WIDTH = tps_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_start_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_lower_prime,
   output logic [VALUE_WIDTH-1:0] rsp_upper_prime,
   output logic                   rsp_pair_found
);
   import tps_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
   localparam logic [VALUE_WIDTH-1:0] GAP       = VALUE_WIDTH'(TWIN_GAP);
   // largest p for which p + 2 still fits
   localparam logic [VALUE_WIDTH-1:0] LIMIT     = VALUE_MAX - GAP;

   ctl_type  ctl;
   stat_type stat;

   logic [VALUE_WIDTH-1:0] p_ff, p_in;       // candidate for the smaller prime
   logic [VALUE_WIDTH-1:0] n_ff, n_in;       // value under test
   logic [VALUE_WIDTH-1:0] d_ff, d_in;       // trial divisor
   logic                   second_ff, second_in;
   logic [VALUE_WIDTH-1:0] lower_ff, lower_in;
   logic [VALUE_WIDTH-1:0] upper_ff, upper_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   div_go, div_busy;
   logic [VALUE_WIDTH-1:0] div_quo, div_rem;
   logic                   rsp_busy, rsp_wr;

   tps_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   tps_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_ready = (ctl.act == ACT_LOAD_P);
   assign div_go    = (ctl.act == ACT_DIV_GO);
   assign rsp_busy  = rsp_valid_ff && !rsp_ready;
   // result only lands when the response register is free
   assign rsp_wr    = ((ctl.act == ACT_WR_FOUND) || (ctl.act == ACT_WR_FAIL)) && !rsp_busy;

   // status seen by the sequencer
   always_comb begin
      stat.no_req   = !req_valid;
      stat.over     = (p_ff > LIMIT);
      stat.le1      = (n_ff <= VALUE_WIDTH'(1));
      stat.lt4      = (n_ff < VALUE_WIDTH'(4));
      stat.even     = !n_ff[0];
      stat.div_busy = div_busy;
      stat.q_lt_d   = (div_quo < d_ff);   // d*d > n: no divisor left
      stat.rem_zero = (div_rem == '0);
      stat.second   = second_ff;
      stat.rsp_free = !rsp_busy;
   end

   always_comb begin
      p_in         = p_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      second_in    = second_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (ctl.act)
         ACT_LOAD_P: begin
            if (req_valid) begin
               p_in = req_start_value;
            end
         end
         ACT_SET_N_P: begin
            n_in      = p_ff;
            second_in = 1'b0;
         end
         ACT_SET_D3:   d_in = VALUE_WIDTH'(3);
         ACT_D_ADD2:   d_in = d_ff + GAP;
         ACT_SET_N_P2: begin
            n_in      = p_ff + GAP;
            second_in = 1'b1;
         end
         ACT_INC_P:    p_in = p_ff + VALUE_WIDTH'(1);
         ACT_WR_FOUND: begin
            lower_in = p_ff;
            upper_in = p_ff + GAP;
            found_in = 1'b1;
         end
         ACT_WR_FAIL: begin
            lower_in = '0;
            upper_in = '0;
            found_in = 1'b0;
         end
         default: begin
         end
      endcase
      if (!rsp_wr) begin
         lower_in = lower_ff;
         upper_in = upper_ff;
         found_in = found_ff;
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff      <= p_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      second_ff <= second_in;
      lower_ff  <= lower_in;
      upper_ff  <= upper_in;
      found_ff  <= found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lower_prime = lower_ff;
   assign rsp_upper_prime = upper_ff;
   assign rsp_pair_found  = found_ff;

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_wr |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten while pending");

   // a found pair is always two apart
   a_pair_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_found) |-> (rsp_upper_prime == rsp_lower_prime + GAP))
      else $error("pair not two apart");

   // a failed search reports zeros
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pair_found) |-> (rsp_lower_prime == '0 && rsp_upper_prime == '0))
      else $error("failed search with non-zero primes");

   // divider is only started when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_busy)
      else $error("divider restarted while busy");

endmodule

### rtl/tps_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package items; VALUE_WIDTH handed down from the top level.
module tps_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   busy,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [VALUE_WIDTH-1:0] remainder
);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [VALUE_WIDTH:0]   shifted, diff;

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(VALUE_WIDTH);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (!diff[VALUE_WIDTH]) begin
            rem_in = diff[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

### rtl/tps_seq.sv
// Microcode sequencer: step counter, program table, conditional jump.
// Depends on tps_pkg for the control word and status bundle.
module tps_seq (
   input  logic              clock,
   input  logic              reset,
   input  tps_pkg::stat_type stat,
   output tps_pkg::ctl_type  ctl
);
   import tps_pkg::*;

   localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LIMIT  = 5'd1;
   localparam logic [STEP_W-1:0] STEP_TEST   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_DIV    = 5'd5;
   localparam logic [STEP_W-1:0] STEP_WAIT   = 5'd6;
   localparam logic [STEP_W-1:0] STEP_PRIME  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_NEXT   = 5'd12;
   localparam logic [STEP_W-1:0] STEP_FOUND  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_FAIL   = 5'd15;

   function automatic ctl_type rom(input logic [STEP_W-1:0] step);
      ctl_type w;
      case (step)
         5'd0:    w = '{COND_NO_REQ,   STEP_IDLE,  ACT_LOAD_P};
         5'd1:    w = '{COND_OVER,     STEP_FAIL,  ACT_SET_N_P};
         5'd2:    w = '{COND_LE1,      STEP_NEXT,  ACT_NONE};
         5'd3:    w = '{COND_LT4,      STEP_PRIME, ACT_NONE};
         5'd4:    w = '{COND_EVEN,     STEP_NEXT,  ACT_SET_D3};
         5'd5:    w = '{COND_NEVER,    STEP_IDLE,  ACT_DIV_GO};
         5'd6:    w = '{COND_DIV_BUSY, STEP_WAIT,  ACT_NONE};
         5'd7:    w = '{COND_Q_LT_D,   STEP_PRIME, ACT_NONE};
         5'd8:    w = '{COND_REM_ZERO, STEP_NEXT,  ACT_NONE};
         5'd9:    w = '{COND_ALWAYS,   STEP_DIV,   ACT_D_ADD2};
         5'd10:   w = '{COND_SECOND,   STEP_FOUND, ACT_NONE};
         5'd11:   w = '{COND_ALWAYS,   STEP_TEST,  ACT_SET_N_P2};
         5'd12:   w = '{COND_ALWAYS,   STEP_LIMIT, ACT_INC_P};
         5'd13:   w = '{COND_RSP_FREE, STEP_IDLE,  ACT_WR_FOUND};
         5'd14:   w = '{COND_ALWAYS,   STEP_FOUND, ACT_NONE};
         5'd15:   w = '{COND_RSP_FREE, STEP_IDLE,  ACT_WR_FAIL};
         5'd16:   w = '{COND_ALWAYS,   STEP_FAIL,  ACT_NONE};
         default: w = '{COND_ALWAYS,   STEP_IDLE,  ACT_NONE};
      endcase
      return w;
   endfunction

   logic [STEP_W-1:0] step_ff, step_in;
   logic              taken;

   assign ctl = rom(step_ff);

   always_comb begin
      case (ctl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = stat.no_req;
         COND_OVER:     taken = stat.over;
         COND_LE1:      taken = stat.le1;
         COND_LT4:      taken = stat.lt4;
         COND_EVEN:     taken = stat.even;
         COND_DIV_BUSY: taken = stat.div_busy;
         COND_Q_LT_D:   taken = stat.q_lt_d;
         COND_REM_ZERO: taken = stat.rem_zero;
         COND_SECOND:   taken = stat.second;
         COND_RSP_FREE: taken = stat.rsp_free;
         default:       taken = 1'b1;
      endcase
      step_in = taken ? ctl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### bench/tb.sv
// Self-checking bench for twin_prime_search: directed and random start values.
// Depends on tps_pkg and the twin_prime_search RTL; predicts each pair in-bench.
`timescale 1ns / 100ps

module tb;

   localparam int VW           = tps_pkg::VALUE_WIDTH_DEFAULT;
   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_COUNT = 84;
   // watchdog for the whole run, with margin over the slowest legal run
   localparam int TIMEOUT_CYCLES = 20_000_000;

   typedef struct packed {
      logic [VW-1:0] lower;
      logic [VW-1:0] upper;
      logic          found;
   } twin_pair_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_start_value = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VW-1:0] rsp_lower_prime;
   logic [VW-1:0] rsp_upper_prime;
   logic          rsp_pair_found;

   // pairs owed by the block, oldest first
   twin_pair_type pairs_owed[$];
   int            mismatches = 0;
   // when set, neither side idles
   bit            free_flow = 1'b0;
   int            ready_hold = 0;

   twin_prime_search #(.VALUE_WIDTH(VW)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_value (req_start_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_lower_prime (rsp_lower_prime),
      .rsp_upper_prime (rsp_upper_prime),
      .rsp_pair_found  (rsp_pair_found)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // trial division; d <= n/d avoids overflow of d*d
   function automatic bit trial_division_prime(longint unsigned n);
      longint unsigned d;
      if (n <= 1) return 1'b0;
      if (n < 4) return 1'b1;
      if (n % 2 == 0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // walk p upward from the start until a pair fits below the top of the range
   function automatic twin_pair_type predict_twin_pair(logic [VW-1:0] start);
      longint unsigned top;
      longint unsigned p;
      twin_pair_type   pair;
      top  = ((64'd1 << VW) - 64'd1) - 64'(tps_pkg::TWIN_GAP);
      p    = 64'(start);
      pair = '0;
      while (p <= top) begin
         if (trial_division_prime(p) && trial_division_prime(p + tps_pkg::TWIN_GAP)) begin
            pair.lower = VW'(p);
            pair.upper = VW'(p + tps_pkg::TWIN_GAP);
            pair.found = 1'b1;
            return pair;
         end
         p++;
      end
      // ran past the width: all fields zero
      return pair;
   endfunction

   // ---------------------------------------------------------------------
   // Idling
   // ---------------------------------------------------------------------

   // mostly none or short, now and then a long gap
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (free_flow || r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(16, 120);
   endfunction

   // response side back-pressure
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!free_flow && $urandom_range(0, 5) == 0)
            ready_hold = idle_cycles();
      end
   end

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // Valid is only lowered ahead of a real gap, so back-to-back requests
   // never see a low and a high scheduled in the same step.
   task automatic send_start(input logic [VW-1:0] value);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_value <= value;
      do @(posedge clock); while (!req_ready);
      pairs_owed.push_back(predict_twin_pair(value));
   endtask

   // hold the request side off until the block has returned everything
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pairs_owed.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : check_pairs
      twin_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pairs_owed.size() == 0) begin
            $error("unexpected response: lower %0d upper %0d found %0b",
                   rsp_lower_prime, rsp_upper_prime, rsp_pair_found);
            mismatches++;
         end else begin
            want = pairs_owed.pop_front();
            if (rsp_lower_prime !== want.lower) begin
               $error("lower_prime: expected %0d, actual %0d", want.lower, rsp_lower_prime);
               mismatches++;
            end
            if (rsp_upper_prime !== want.upper) begin
               $error("upper_prime: expected %0d, actual %0d", want.upper, rsp_upper_prime);
               mismatches++;
            end
            if (rsp_pair_found !== want.found) begin
               $error("pair_found: expected %0b, actual %0b", want.found, rsp_pair_found);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // 0 and 1 are not prime and 2 pairs with nothing: starts 0 to 3 land on (3, 5)
   task automatic test_low_starts();
      logic [VW-1:0] v;
      free_flow = 1'b1;
      for (v = '0; v < VW'(8); v++) send_start(v);
      free_flow = 1'b0;
      send_start(VW'(17));
      send_start(VW'(100));
   endtask

   // alternating bit patterns in the low 12 bits, and the top of 16 bits
   task automatic test_bit_patterns();
      send_start(VW'(12'h555));
      send_start(VW'(12'hAAA));
      send_start(VW'(16'hFFFF));
   endtask

   // starts near the top of the range: the search runs out of width
   task automatic test_range_exhausted();
      // pause until the block is empty before the slow ones
      drain_results();
      send_start({VW{1'b1}});
      send_start({{(VW-1){1'b1}}, 1'b0});
      // top minus two is composite with a large smallest factor, then stops
      send_start({{(VW-2){1'b1}}, 2'b01});
      drain_results();
   endtask

   // mostly small starts to keep the search short, a few wide ones
   task automatic test_random_starts();
      int            n;
      int            r;
      logic [VW-1:0] v;
      for (n = 0; n < RANDOM_COUNT; n++) begin
         // a stretch with no idling at all, then random gaps
         free_flow = (n < 25);
         r = $urandom_range(0, 99);
         if (r < 3)
            v = {{(VW-1){1'b1}}, 1'($urandom_range(0, 1))};
         else if (r < 8)
            v = VW'($urandom_range(4096, 65535));
         else if (r < 35)
            v = VW'($urandom_range(1024, 4095));
         else
            v = VW'($urandom_range(0, 1023));
         send_start(v);
      end
      free_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_low_starts();
      test_bit_patterns();
      test_range_exhausted();
      test_random_starts();

      req_valid <= 1'b0;
      while (pairs_owed.size() != 0) @(posedge clock);
      // catch any stray extra response
      repeat (50) @(posedge clock);

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
